FILE: rtl/core/slle_pkg.sv
// shared types and constants of the static linked list engine
`timescale 1ns / 1ps

package slle_pkg;

  localparam int OPC_W  = 2;
  localparam int POS_W  = 6;
  localparam int DATA_W = 8;
  localparam int LEN_W  = 6;

  localparam logic [OPC_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OPC_W-1:0] OP_DELETE   = 2'd1;
  localparam logic [OPC_W-1:0] OP_TRAVERSE = 2'd2;

  // read address source for both slot memories
  typedef enum logic [1:0] {
    RD_FREE,
    RD_WALK,
    RD_HEAD,
    RD_CHAIN
  } rd_sel_e;

  // link update performed in a cycle
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_FR_LINK,
    WR_PREV_FR,
    WR_PREV_VNEXT,
    WR_VICTIM_FREE
  } wr_sel_e;

  // kind of result beat loaded into the output register
  typedef enum logic [1:0] {
    EM_NONE,
    EM_OK,
    EM_ERR,
    EM_ELEM
  } emit_e;

  typedef struct packed {
    logic    init_step;
    logic    load_op;
    logic    walk_start;
    logic    walk_step;
    logic    walk_done;
    logic    fetch_free;
    logic    free_pop;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    trav_start;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    emit_e   emit;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic free_empty;
    logic count_zero;
    logic steps_zero;
    logic rem_last;
  } stat_t;

endpackage

FILE: rtl/core/static_linked_list_engine.sv
// top level of the static linked list engine with free chain
`timescale 1ns / 1ps

// usage
//   a command beat (opcode_i, position_i, element_value_i) is taken at a rising
//   edge with start high and busy low; opcode 0 inserts a byte before a
//   1-based position, 1 deletes the element at a position, 2 traverses
//   each result beat shows for one cycle with result_valid_o high; the
//   receiver cannot stall, so every strobe is a delivered beat
//   after reset the block sweeps the link memory to build the free chain
//   with busy high, then the list is empty
//   an error or empty traverse answers straight from idle; insert pops a free
//   slot, walks to position p and relinks; delete walks and unlinks; a
//   traverse with n elements gives n beats, one per cycle
//   the walk over the link chain, one slot per cycle through the link
//   memory read port, sets how long an item takes; busy drops in the cycle
//   of the last result beat
module static_linked_list_engine #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [slle_pkg::OPC_W-1:0]  opcode_i,
  input  logic [slle_pkg::POS_W-1:0]  position_i,
  input  logic [slle_pkg::DATA_W-1:0] element_value_i,
  output logic                        result_valid_o,
  output logic                        status_o,
  output logic [slle_pkg::DATA_W-1:0] element_out_o,
  output logic                        element_valid_o,
  output logic [slle_pkg::LEN_W-1:0]  list_length_o,
  output logic                        last_result_o
);

  import slle_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: init sweep, range checks, walk, relink and traverse steps
  slle_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // datapath: link and data memories, free and header links, counters
  slle_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .position_i      (position_i),
    .element_value_i (element_value_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .element_out_o   (element_out_o),
    .element_valid_o (element_valid_o),
    .list_length_o   (list_length_o),
    .last_result_o   (last_result_o)
  );

endmodule

FILE: rtl/core/slle_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module slle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/slle_ctrl.sv
// sequencing state machine of the static linked list engine
`timescale 1ns / 1ps

module slle_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [slle_pkg::OPC_W-1:0] opcode_i,
  input  slle_pkg::stat_t           stat_i,
  output slle_pkg::cmd_t            cmd_o
);

  import slle_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_FETCH,
    S_POP,
    S_WALK,
    S_INS_LINK,
    S_INS_PREV,
    S_DEL_UNLINK,
    S_DEL_FREE,
    S_TRAV
  } state_e;

  state_e           state_q, state_d;
  logic [OPC_W-1:0] op_q, op_d;
  logic             accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '{rd_sel: RD_HEAD, wr_sel: WR_NONE, emit: EM_NONE, default: 1'b0};
    case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        cmd_o.wr_sel    = WR_INIT;
        if (stat_i.init_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d          = opcode_i;
          cmd_o.load_op = 1'b1;
          case (opcode_i)
            OP_INSERT: begin
              if (!stat_i.ins_pos_ok || stat_i.free_empty) begin
                cmd_o.emit = EM_ERR;
              end else begin
                state_d = S_FETCH;
              end
            end
            OP_DELETE: begin
              if (!stat_i.del_pos_ok) begin
                cmd_o.emit = EM_ERR;
              end else begin
                cmd_o.walk_start = 1'b1;
                state_d          = S_WALK;
              end
            end
            OP_TRAVERSE: begin
              if (stat_i.count_zero) begin
                cmd_o.emit = EM_OK;
              end else begin
                cmd_o.trav_start = 1'b1;
                state_d          = S_TRAV;
              end
            end
            default: begin
              cmd_o.emit = EM_ERR;
            end
          endcase
        end
      end
      S_FETCH: begin
        cmd_o.rd_sel     = RD_FREE;
        cmd_o.fetch_free = 1'b1;
        state_d          = S_POP;
      end
      S_POP: begin
        cmd_o.free_pop   = 1'b1;
        cmd_o.walk_start = 1'b1;
        state_d          = S_WALK;
      end
      S_WALK: begin
        cmd_o.rd_sel = RD_WALK;
        if (stat_i.steps_zero) begin
          cmd_o.walk_done = 1'b1;
          state_d = (op_q == OP_INSERT) ? S_INS_LINK : S_DEL_UNLINK;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_INS_LINK: begin
        cmd_o.wr_sel = WR_FR_LINK;
        state_d      = S_INS_PREV;
      end
      S_INS_PREV: begin
        cmd_o.wr_sel  = WR_PREV_FR;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.emit    = EM_OK;
        state_d       = S_IDLE;
      end
      S_DEL_UNLINK: begin
        cmd_o.wr_sel = WR_PREV_VNEXT;
        state_d      = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd_o.wr_sel  = WR_VICTIM_FREE;
        cmd_o.cnt_dec = 1'b1;
        cmd_o.emit    = EM_OK;
        state_d       = S_IDLE;
      end
      S_TRAV: begin
        cmd_o.rd_sel = RD_CHAIN;
        cmd_o.emit   = EM_ELEM;
        if (stat_i.rem_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= OP_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

FILE: rtl/core/slle_datapath.sv
// slot memories, pointers, counters and result register of the list engine
`timescale 1ns / 1ps

module slle_datapath #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slle_pkg::cmd_t              cmd_i,
  output slle_pkg::stat_t             stat_o,
  input  logic [slle_pkg::POS_W-1:0]  position_i,
  input  logic [slle_pkg::DATA_W-1:0] element_value_i,
  output logic                        result_valid_o,
  output logic                        status_o,
  output logic [slle_pkg::DATA_W-1:0] element_out_o,
  output logic                        element_valid_o,
  output logic [slle_pkg::LEN_W-1:0]  list_length_o,
  output logic                        last_result_o
);

  import slle_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = (IW > LEN_W) ? IW : LEN_W;
  localparam logic [IW-1:0] HEAD = IW'(SLOT_COUNT - 1);
  localparam logic [IW-1:0] LAST_FREE = IW'(SLOT_COUNT - 2);

  logic [IW-1:0]     free_head_q, free_head_d;
  logic [IW-1:0]     head_q, head_d;
  logic [IW-1:0]     cur_q, prev_q, link_q, fr_q, init_idx_q;
  logic [POS_W-1:0]  steps_q, pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count_q, count_d, rem_q;

  logic [IW-1:0]     nrd, nxt_w, raddr;
  logic              nwe;
  logic [IW-1:0]     nwaddr, nwdata;
  logic [DATA_W-1:0] drd;
  logic [POS_W-1:0]  pos_sel;
  logic [CW:0]       pos_ext;

  logic              res_valid_q, status_q, elem_valid_q, last_q;
  logic [DATA_W-1:0] elem_q;
  logic [LEN_W-1:0]  len_q;

  // successor of the walk cursor: header link lives in a register
  assign nxt_w = (cur_q == HEAD) ? head_q : nrd;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FREE:  raddr = free_head_q;
      RD_WALK:  raddr = nxt_w;
      RD_HEAD:  raddr = head_q;
      RD_CHAIN: raddr = nrd;
      default:  raddr = head_q;
    endcase
  end

  always_comb begin
    nwe         = 1'b0;
    nwaddr      = prev_q;
    nwdata      = fr_q;
    head_d      = head_q;
    free_head_d = cmd_i.free_pop ? nrd : free_head_q;
    case (cmd_i.wr_sel)
      WR_INIT: begin
        nwe    = 1'b1;
        nwaddr = init_idx_q;
        nwdata = (init_idx_q < LAST_FREE) ? init_idx_q + IW'(1) : '0;
      end
      WR_FR_LINK: begin
        nwe    = 1'b1;
        nwaddr = fr_q;
        nwdata = link_q;
      end
      WR_PREV_FR: begin
        if (prev_q == HEAD) begin
          head_d = fr_q;
        end else begin
          nwe = 1'b1;
        end
      end
      WR_PREV_VNEXT: begin
        nwdata = nrd;
        if (prev_q == HEAD) begin
          head_d = nrd;
        end else begin
          nwe = 1'b1;
        end
      end
      WR_VICTIM_FREE: begin
        nwe         = 1'b1;
        nwaddr      = link_q;
        nwdata      = free_head_q;
        free_head_d = link_q;
      end
      default: begin
        nwe = 1'b0;
      end
    endcase
  end

  slle_ram #(
    .WIDTH (IW),
    .DEPTH (SLOT_COUNT)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nwe),
    .waddr_i (nwaddr),
    .wdata_i (nwdata),
    .raddr_i (raddr),
    .rdata_o (nrd)
  );

  slle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOT_COUNT)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fetch_free),
    .waddr_i (free_head_q),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (drd)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  assign pos_sel = cmd_i.load_op ? position_i : pos_q;
  assign pos_ext = (CW + 1)'(position_i);

  assign stat_o.init_done  = (init_idx_q == HEAD);
  assign stat_o.ins_pos_ok = (position_i != '0) && (pos_ext <= ({1'b0, count_q} + (CW + 1)'(1)));
  assign stat_o.del_pos_ok = (position_i != '0) && (pos_ext <= {1'b0, count_q});
  assign stat_o.free_empty = (free_head_q == '0);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.steps_zero = (steps_q == '0);
  assign stat_o.rem_last   = (rem_q == CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= IW'(1);
      head_q      <= '0;
      count_q     <= '0;
      init_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      head_q      <= head_d;
      count_q     <= count_d;
      if (cmd_i.init_step && (init_idx_q != HEAD)) begin
        init_idx_q <= init_idx_q + IW'(1);
      end
      res_valid_q <= (cmd_i.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      pos_q <= position_i;
      val_q <= element_value_i;
    end
    if (cmd_i.fetch_free) begin
      fr_q <= free_head_q;
    end
    if (cmd_i.walk_start) begin
      cur_q   <= HEAD;
      steps_q <= pos_sel - POS_W'(1);
    end else if (cmd_i.walk_step) begin
      cur_q   <= nxt_w;
      steps_q <= steps_q - POS_W'(1);
    end
    if (cmd_i.walk_done) begin
      prev_q <= cur_q;
      link_q <= nxt_w;
    end
    if (cmd_i.trav_start) begin
      rem_q <= count_q;
    end else if (cmd_i.emit == EM_ELEM) begin
      rem_q <= rem_q - CW'(1);
    end
    status_q     <= (cmd_i.emit == EM_ERR);
    elem_q       <= (cmd_i.emit == EM_ELEM) ? drd : '0;
    elem_valid_q <= (cmd_i.emit == EM_ELEM);
    last_q       <= (cmd_i.emit != EM_ELEM) || (rem_q == CW'(1));
    len_q        <= count_d[LEN_W-1:0];
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = status_q;
  assign element_out_o   = elem_q;
  assign element_valid_o = elem_valid_q;
  assign list_length_o   = len_q;
  assign last_result_o   = last_q;

endmodule

FILE: dv/static_linked_list_engine_tb.sv
// self-checking testbench of the static linked list engine: directed, fill and random commands
`timescale 1ns / 1ps

module static_linked_list_engine_tb;
  import slle_pkg::*;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int HEAD_SLOT = SLOT_COUNT - 1;
  localparam int LIST_CAP = SLOT_COUNT - 2;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  // longest quiet stretch: reset sweep, or an idle gap plus an insert near the tail
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = SLOT_COUNT + 16;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] elem;
    logic              elem_valid;
    logic [LEN_W-1:0]  length;
    logic              last;
  } list_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OPC_W-1:0]  opcode_i = '0;
  logic [POS_W-1:0]  position_i = '0;
  logic [DATA_W-1:0] element_value_i = '0;
  logic              result_valid_o;
  logic              status_o;
  logic [DATA_W-1:0] element_out_o;
  logic              element_valid_o;
  logic [LEN_W-1:0]  list_length_o;
  logic              last_result_o;

  static_linked_list_engine #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .element_value_i(element_value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .element_out_o  (element_out_o),
    .element_valid_o(element_valid_o),
    .list_length_o  (list_length_o),
    .last_result_o  (last_result_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow copy of the slot arrays and the element counter
  logic [SLOT_W-1:0] link_mem [SLOT_COUNT];
  logic [DATA_W-1:0] byte_mem [SLOT_COUNT];
  int                list_count;
  list_beat_t        list_beats_q[$];

  bit idle_enable = 1'b1;
  int fail_count = 0;
  int n_insert = 0, n_delete = 0, n_traverse = 0, n_error = 0;
  int n_beats = 0, n_drains = 0, peak_count = 0;
  int quiet_cycles = 0;

  task automatic reset_list_model();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      link_mem[i] = SLOT_W'(i + 1);
      byte_mem[i] = '0;
    end
    // free chain stops short of the header, header list empty
    link_mem[SLOT_COUNT-2] = '0;
    link_mem[HEAD_SLOT] = '0;
    list_count = 0;
  endtask

  function automatic logic [SLOT_W-1:0] slot_before(int steps);
    logic [SLOT_W-1:0] idx;
    idx = SLOT_W'(HEAD_SLOT);
    for (int j = 0; j < steps; j++) idx = link_mem[idx];
    return idx;
  endfunction

  task automatic push_beat(logic status, logic [DATA_W-1:0] elem, logic elem_valid, logic last);
    list_beat_t b;
    b.status = status;
    b.elem = elem;
    b.elem_valid = elem_valid;
    b.length = LEN_W'(list_count);
    b.last = last;
    list_beats_q.push_back(b);
    if (status) n_error++;
  endtask

  // update the shadow list with one accepted command and queue its result beats
  task automatic apply_list_op(logic [OPC_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] value);
    logic [SLOT_W-1:0] fresh, prev, victim, idx;
    case (op)
      OP_INSERT: begin
        n_insert++;
        fresh = link_mem[0];
        if (pos == 0 || int'(pos) > list_count + 1 || fresh == 0) begin
          push_beat(1'b1, '0, 1'b0, 1'b1);
        end else begin
          link_mem[0] = link_mem[fresh];
          byte_mem[fresh] = value;
          prev = slot_before(int'(pos) - 1);
          link_mem[fresh] = link_mem[prev];
          link_mem[prev] = fresh;
          list_count++;
          if (list_count > peak_count) peak_count = list_count;
          push_beat(1'b0, '0, 1'b0, 1'b1);
        end
      end
      OP_DELETE: begin
        n_delete++;
        if (pos == 0 || int'(pos) > list_count) begin
          push_beat(1'b1, '0, 1'b0, 1'b1);
        end else begin
          prev = slot_before(int'(pos) - 1);
          victim = link_mem[prev];
          link_mem[prev] = link_mem[victim];
          link_mem[victim] = link_mem[0];
          link_mem[0] = victim;
          list_count--;
          push_beat(1'b0, '0, 1'b0, 1'b1);
        end
      end
      OP_TRAVERSE: begin
        n_traverse++;
        if (list_count == 0) begin
          push_beat(1'b0, '0, 1'b0, 1'b1);
        end else begin
          idx = link_mem[HEAD_SLOT];
          for (int k = 0; k < list_count; k++) begin
            push_beat(1'b0, byte_mem[idx], 1'b1, k == list_count - 1);
            idx = link_mem[idx];
          end
        end
      end
      default: push_beat(1'b1, '0, 1'b0, 1'b1);
    endcase
  endtask

  // one command beat; start is left high so a following call keeps it up
  task automatic send_cmd(logic [OPC_W-1:0] op, logic [POS_W-1:0] pos,
                          logic [DATA_W-1:0] value);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    position_i <= pos;
    element_value_i <= value;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_list_op(op, pos, value);
  endtask

  // hold off new commands until every queued beat has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (list_beats_q.size() != 0) @(posedge clk_i);
    n_drains++;
  endtask

  task automatic test_basic_ops();
    send_cmd(OP_TRAVERSE, '0, '0);         // empty list traverse
    send_cmd(OP_DELETE, 6'd1, 8'h00);      // delete from empty list
    send_cmd(OP_INSERT, 6'd0, 8'hFF);      // position zero
    send_cmd(OP_INSERT, 6'd2, 8'hFF);      // past end of empty list
    send_cmd(OP_UNUSED, 6'h3F, 8'hFF);     // unknown opcode
    send_cmd(OP_INSERT, 6'd1, 8'hFF);
    send_cmd(OP_INSERT, 6'd1, 8'h00);      // new head
    send_cmd(OP_INSERT, 6'd3, 8'hA5);      // append at tail
    send_cmd(OP_INSERT, 6'd2, 8'h5A);      // middle
    send_cmd(OP_TRAVERSE, 6'h3F, 8'hFF);
    send_cmd(OP_INSERT, 6'd6, 8'h11);      // one past count + 1
    send_cmd(OP_INSERT, 6'h3F, 8'h22);     // top position
    send_cmd(OP_DELETE, 6'd5, 8'hFF);      // one past count
    send_cmd(OP_DELETE, 6'd4, 8'h00);      // tail
    send_cmd(OP_DELETE, 6'd0, 8'h00);
    send_cmd(OP_DELETE, 6'd1, 8'h00);      // head
    send_cmd(OP_TRAVERSE, '0, '0);
    send_cmd(OP_INSERT, 6'd3, 8'h81);      // reuses a freed slot
    send_cmd(OP_DELETE, 6'd2, 8'h7E);
    send_cmd(OP_UNUSED, '0, '0);
    send_cmd(OP_TRAVERSE, '0, '0);
    wait_drained();
  endtask

  task automatic test_full_store();
    while (list_count < LIST_CAP)
      send_cmd(OP_INSERT, POS_W'($urandom_range(1, list_count + 1)),
               DATA_W'($urandom_range(0, 255)));
    send_cmd(OP_INSERT, POS_W'(LIST_CAP + 1), 8'hC3); // valid position, no free slot
    send_cmd(OP_INSERT, 6'd1, 8'h3C);
    send_cmd(OP_TRAVERSE, '0, '0);                     // longest burst of beats
    send_cmd(OP_DELETE, POS_W'(LIST_CAP), 8'h00);
    send_cmd(OP_DELETE, 6'h3F, 8'h00);
    send_cmd(OP_INSERT, POS_W'(list_count + 1), 8'h96);
    send_cmd(OP_TRAVERSE, '0, '0);
    while (list_count > 8)
      send_cmd(OP_DELETE, POS_W'($urandom_range(1, list_count)),
               DATA_W'($urandom_range(0, 255)));
    wait_drained();
  endtask

  task automatic test_random_ops(int n_items);
    int r;
    bit grow;
    logic [OPC_W-1:0] op;
    logic [POS_W-1:0] pos;
    for (int i = 0; i < n_items; i++) begin
      idle_enable = (i < n_items - 60);
      // alternate growing and shrinking phases to sweep the fill level
      grow = ((i / 100) % 2) == 0;
      r = $urandom_range(0, 99);
      pos = POS_W'($urandom_range(0, 63));
      if (r < 6) begin
        op = OPC_W'($urandom_range(0, 1));     // position noise
      end else if (r < 10) begin
        op = OP_UNUSED;
      end else if (r < 20) begin
        op = OP_TRAVERSE;
      end else if (r < (grow ? 80 : 50)) begin
        op = OP_INSERT;
        pos = POS_W'($urandom_range(1, list_count + 1));
      end else begin
        op = OP_DELETE;
        if (list_count > 0) pos = POS_W'($urandom_range(1, list_count));
      end
      send_cmd(op, pos, DATA_W'($urandom_range(0, 255)));
      if (i == n_items / 2) wait_drained();
    end
  endtask

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // every strobe is a delivered beat; compare against the oldest queued one
  always @(posedge clk_i) begin : beat_check
    list_beat_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (list_beats_q.size() == 0) begin
        $display("%0t ns: result beat with none expected, actual status %0b elem %0h len %0d",
                 $time, status_o, element_out_o, list_length_o);
        fail_count++;
      end else begin
        want = list_beats_q.pop_front();
        n_beats++;
        check_field("status", DATA_W'(want.status), DATA_W'(status_o));
        check_field("element_out", want.elem, element_out_o);
        check_field("element_valid", DATA_W'(want.elem_valid), DATA_W'(element_valid_o));
        check_field("list_length", DATA_W'(want.length), DATA_W'(list_length_o));
        check_field("last_result", DATA_W'(want.last), DATA_W'(last_result_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || result_valid_o === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t ns: no beat moved for %0d cycles, %0d beats still expected",
             $time, STALL_LIMIT, list_beats_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    reset_list_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_full_store();
    test_random_ops(260);
    start <= 1'b0;
    while (list_beats_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d inserts, %0d deletes, %0d traverses, %0d error results, peak length %0d",
             n_insert, n_delete, n_traverse, n_error, peak_count);
    $display("checked %0d result beats over %0d full drains, %0d mismatches",
             n_beats, n_drains, fail_count);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: static_linked_list_engine.f
rtl/core/slle_pkg.sv
rtl/core/slle_ram.sv
rtl/core/slle_ctrl.sv
rtl/core/slle_datapath.sv
rtl/core/static_linked_list_engine.sv
dv/static_linked_list_engine_tb.sv
